// File: rtl/eoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eoc_pkg;

  localparam int NUM_FLOORS  = 4;
  localparam int FLOOR_W     = 4;
  localparam int IDX_W       = (NUM_FLOORS > 2) ? $clog2(NUM_FLOORS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] TOP_FLOOR    = IDX_W'(NUM_FLOORS - 1);
  localparam logic [IDX_W-1:0] BOTTOM_FLOOR = '0;

  localparam logic CMD_PRESS = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] KIND_CAB  = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  localparam int ORD_CAB  = 0;
  localparam int ORD_UP   = 1;
  localparam int ORD_DOWN = 2;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_UP   = 2'd1;
  localparam logic [1:0] MOTOR_DOWN = 2'd2;
  localparam logic [1:0] MOTOR_STOP = 2'd3;

  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PRESS,
    OP_STEP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [2:0]       mask;
    logic [IDX_W-1:0] flr;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/eoc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module eoc_front (
  input  wire logic                   start_i,
  input  wire logic                   cmd_i,
  input  wire logic [1:0]             button_kind_i,
  input  wire logic [3:0]             floor_i,
  input  wire logic                   at_floor_i,
  input  wire logic                   full_i,
  output logic                        busy_o,
  output logic                        push_o,
  output eoc_pkg::item_t              item_o
);

  logic                      in_range;
  logic [eoc_pkg::IDX_W-1:0] flr;
  logic [2:0]                mask;

  assign in_range = ({1'b0, floor_i} < (eoc_pkg::FLOOR_W + 1)'(eoc_pkg::NUM_FLOORS));
  assign flr      = floor_i[eoc_pkg::IDX_W-1:0];
  assign busy_o   = full_i;
  assign push_o   = start_i & ~full_i;

  always_comb begin
    mask = 3'b000;
    unique case (button_kind_i)
      eoc_pkg::KIND_CAB: begin
        mask[eoc_pkg::ORD_CAB] = 1'b1;
      end
      eoc_pkg::KIND_UP: begin
        mask[eoc_pkg::ORD_UP] = (flr != eoc_pkg::TOP_FLOOR);
      end
      eoc_pkg::KIND_DOWN: begin
        mask[eoc_pkg::ORD_DOWN] = (flr != eoc_pkg::BOTTOM_FLOOR);
      end
      default: begin
        mask = 3'b000;
      end
    endcase
  end

  always_comb begin
    item_o.flr  = flr;
    item_o.mask = mask;
    unique case (cmd_i)
      eoc_pkg::CMD_PRESS: begin
        item_o.op = (in_range && (mask != 3'b000)) ? eoc_pkg::OP_PRESS : eoc_pkg::OP_NONE;
      end
      default: begin
        item_o.op = (in_range && at_floor_i) ? eoc_pkg::OP_STEP : eoc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/eoc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module eoc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire eoc_pkg::item_t item_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output eoc_pkg::item_t      item_o
);

  eoc_pkg::item_t             mem_q [eoc_pkg::QUEUE_DEPTH];
  logic [eoc_pkg::QPTR_W-1:0] wptr_q, wptr_d;
  logic [eoc_pkg::QPTR_W-1:0] rptr_q, rptr_d;
  logic [eoc_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (cnt_q == eoc_pkg::QCNT_W'(eoc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == eoc_pkg::QPTR_W'(eoc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == eoc_pkg::QPTR_W'(eoc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/eoc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module eoc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire eoc_pkg::item_t item_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [1:0]          motor_cmd_o,
  output logic signed [1:0]   direction_o,
  output logic                door_open_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                    state_q;
  eoc_pkg::item_t            item_q;
  logic [2:0]                pend_q [eoc_pkg::NUM_FLOORS];
  logic [2:0]                pend_d;
  logic [1:0]                dir_q, dir_d;
  logic                      done_q;
  logic [1:0]                motor_q, motor_d;
  logic [1:0]                dir_out_q;
  logic                      door_q, door_d;

  logic [eoc_pkg::IDX_W-1:0] loc;
  logic [2:0]                here;
  logic                      stop;
  logic                      above;
  logic                      below;
  logic [2:0]                any_kind;
  logic [2:0]                low_kind;
  logic                      at_top;
  logic                      at_bottom;
  logic [1:0]                mdir;

  assign loc       = item_q.flr;
  assign here      = pend_q[loc];
  assign at_top    = (loc == eoc_pkg::TOP_FLOOR);
  assign at_bottom = (loc == eoc_pkg::BOTTOM_FLOOR);
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    above    = 1'b0;
    below    = 1'b0;
    any_kind = 3'b000;
    low_kind = 3'b000;
    for (int f = 0; f < eoc_pkg::NUM_FLOORS; f++) begin
      if (eoc_pkg::IDX_W'(f) > loc) begin
        above = above | (|pend_q[f]);
      end
      if (eoc_pkg::IDX_W'(f) < loc) begin
        below = below | (|pend_q[f]);
      end
      if (eoc_pkg::IDX_W'(f) <= loc) begin
        low_kind = low_kind | pend_q[f];
      end
      any_kind = any_kind | pend_q[f];
    end
  end

  assign stop = here[eoc_pkg::ORD_CAB]
              | (here[eoc_pkg::ORD_UP] & (dir_q != eoc_pkg::DIR_DOWN))
              | (here[eoc_pkg::ORD_DOWN] & (dir_q != eoc_pkg::DIR_UP));

  always_comb begin
    pend_d  = here;
    dir_d   = dir_q;
    motor_d = eoc_pkg::MOTOR_NONE;
    door_d  = 1'b0;
    mdir    = dir_q;
    if (item_q.op == eoc_pkg::OP_PRESS) begin
      pend_d = here | item_q.mask;
    end else if (item_q.op == eoc_pkg::OP_STEP) begin
      if (stop) begin
        door_d  = 1'b1;
        motor_d = eoc_pkg::MOTOR_STOP;
        unique case (dir_q)
          eoc_pkg::DIR_UP: begin
            pend_d = here & ~3'b011;
            if (!above) dir_d = eoc_pkg::DIR_IDLE;
          end
          eoc_pkg::DIR_DOWN: begin
            pend_d = here & ~3'b101;
            if (!below) dir_d = eoc_pkg::DIR_IDLE;
          end
          default: begin
            pend_d = 3'b000;
          end
        endcase
      end else begin
        if (dir_q == eoc_pkg::DIR_IDLE) begin
          if (any_kind[eoc_pkg::ORD_CAB]) begin
            mdir = low_kind[eoc_pkg::ORD_CAB] ? eoc_pkg::DIR_DOWN : eoc_pkg::DIR_UP;
          end else if (any_kind[eoc_pkg::ORD_UP]) begin
            mdir = low_kind[eoc_pkg::ORD_UP] ? eoc_pkg::DIR_DOWN : eoc_pkg::DIR_UP;
          end else if (any_kind[eoc_pkg::ORD_DOWN]) begin
            mdir = low_kind[eoc_pkg::ORD_DOWN] ? eoc_pkg::DIR_DOWN : eoc_pkg::DIR_UP;
          end
        end else begin
          if ((dir_q == eoc_pkg::DIR_UP && (!above || at_top))
              || (dir_q == eoc_pkg::DIR_DOWN && (!below || at_bottom))) begin
            mdir = eoc_pkg::DIR_IDLE;
          end
        end
        dir_d = mdir;
        if (dir_q == eoc_pkg::DIR_IDLE && mdir == eoc_pkg::DIR_IDLE) begin
          motor_d = eoc_pkg::MOTOR_NONE;
        end else if (mdir == eoc_pkg::DIR_UP) begin
          motor_d = at_top ? eoc_pkg::MOTOR_NONE : eoc_pkg::MOTOR_UP;
        end else if (mdir == eoc_pkg::DIR_DOWN) begin
          motor_d = at_bottom ? eoc_pkg::MOTOR_NONE : eoc_pkg::MOTOR_DOWN;
        end else begin
          motor_d = eoc_pkg::MOTOR_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      dir_q     <= eoc_pkg::DIR_IDLE;
      motor_q   <= eoc_pkg::MOTOR_NONE;
      dir_out_q <= eoc_pkg::DIR_IDLE;
      door_q    <= 1'b0;
      for (int f = 0; f < eoc_pkg::NUM_FLOORS; f++) begin
        pend_q[f] <= 3'b000;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          done_q      <= 1'b1;
          dir_q       <= dir_d;
          pend_q[loc] <= pend_d;
          motor_q     <= motor_d;
          dir_out_q   <= dir_d;
          door_q      <= door_d;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
  end

  assign done_o      = done_q;
  assign motor_cmd_o = motor_q;
  assign direction_o = dir_out_q;
  assign door_open_o = door_q;

endmodule

`default_nettype wire

// File: rtl/elevator_order_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Elevator order controller.
// Command channel: an item (cmd_i, button_kind_i, floor_i, at_floor_i) transfers
// at a rising edge where start_i is high and busy_o is low. A button press marks
// a pending order; a floor sensor step at a floor decides the car's next action.
// Result channel: every accepted item gives exactly one result (motor_cmd_o,
// direction_o, door_open_o), shown for one cycle with done_o high.
// The front classifies items into a two-entry queue; the back executes each item
// by fetching it from the queue, then deciding and updating the order table.
// The back fetches a new item from the queue only once it has finished the last;
// busy_o rises only while both queue entries are held.
// The receiver cannot stall: each result transfers in its single done_o cycle.
// Reset: all pending orders clear, the car is idle, the queue is empty and
// done_o is low.

module elevator_order_controller (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire logic         cmd_i,
  input  wire logic [1:0]   button_kind_i,
  input  wire logic [3:0]   floor_i,
  input  wire logic         at_floor_i,
  output logic              done_o,
  output logic [1:0]        motor_cmd_o,
  output logic signed [1:0] direction_o,
  output logic              door_open_o
);

  eoc_pkg::item_t front_item;
  eoc_pkg::item_t queue_item;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  eoc_front u_front (
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .button_kind_i (button_kind_i),
    .floor_i       (floor_i),
    .at_floor_i    (at_floor_i),
    .full_i        (full),
    .busy_o        (busy_o),
    .push_o        (push),
    .item_o        (front_item)
  );

  eoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  eoc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .done_o      (done_o),
    .motor_cmd_o (motor_cmd_o),
    .direction_o (direction_o),
    .door_open_o (door_open_o)
  );

  a_door_means_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && door_open_o) |-> (motor_cmd_o == eoc_pkg::MOTOR_STOP))
    else $error("door open without stop");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back produced results in adjacent cycles");

  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (direction_o != 2'b10))
    else $error("illegal direction code");

  a_busy_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !empty)
    else $error("busy with empty queue");

endmodule

`default_nettype wire
